// ===== sv/windowed_pid_step_top_defines.svh =====
// Assertion macros shared by the windowed PID step design.
`ifndef WINDOWED_PID_STEP_TOP_DEFINES_SVH
`define WINDOWED_PID_STEP_TOP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define WPID_ASSERT_SAME(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define WPID_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/wpid_pkg.sv =====
`default_nettype none

package wpid_pkg;

    localparam int DATA_W    = 16;
    localparam int ERR_W     = DATA_W + 1;
    localparam int DERIV_W   = ERR_W + 1;
    localparam int INTEG_W   = 24;
    localparam int GAIN_W    = 16;
    localparam int WIN_W     = 16;
    localparam int LIMIT_W   = 23;
    localparam int DRIVE_W   = 16;
    localparam int PROD_P_W  = ERR_W + GAIN_W;
    localparam int PROD_I_W  = INTEG_W + GAIN_W;
    localparam int PROD_D_W  = DERIV_W + GAIN_W;
    localparam int SUM_W     = PROD_I_W + 2;
    localparam int ADDR_W    = 5;
    localparam int PDATA_W   = 32;
    localparam int REG_IDX_W = 3;

    typedef logic [REG_IDX_W-1:0] reg_idx_t;

    localparam reg_idx_t REG_GAIN_P     = 3'd0;
    localparam reg_idx_t REG_GAIN_I     = 3'd1;
    localparam reg_idx_t REG_GAIN_D     = 3'd2;
    localparam reg_idx_t REG_INT_WINDOW = 3'd3;
    localparam reg_idx_t REG_DER_WINDOW = 3'd4;
    localparam reg_idx_t REG_INT_LIMIT  = 3'd5;
    localparam reg_idx_t REG_DEADBAND   = 3'd6;

    localparam logic signed [GAIN_W-1:0] RST_GAIN_P     = 16'sd4096;
    localparam logic signed [GAIN_W-1:0] RST_GAIN_I     = 16'sd0;
    localparam logic signed [GAIN_W-1:0] RST_GAIN_D     = -16'sd3277;
    localparam logic [WIN_W-1:0]         RST_INT_WINDOW = 16'd100;
    localparam logic [WIN_W-1:0]         RST_DER_WINDOW = 16'd150;
    localparam logic [LIMIT_W-1:0]       RST_INT_LIMIT  = 23'd10000;
    localparam logic [WIN_W-1:0]         RST_DEADBAND   = 16'd50;

    typedef struct packed {
        logic signed [GAIN_W-1:0] gain_p;
        logic signed [GAIN_W-1:0] gain_i;
        logic signed [GAIN_W-1:0] gain_d;
        logic [WIN_W-1:0]         integral_window;
        logic [WIN_W-1:0]         derivative_window;
        logic [LIMIT_W-1:0]       integral_limit;
        logic [WIN_W-1:0]         output_deadband;
    } cfg_t;

    // Error, integral and derivative of one word, ready for the multipliers.
    typedef struct packed {
        logic signed [ERR_W-1:0]   err;
        logic signed [INTEG_W-1:0] integ;
        logic signed [DERIV_W-1:0] deriv;
        logic                      in_deadband;
    } s1_t;

    // Weighted terms of one word.
    typedef struct packed {
        logic signed [ERR_W-1:0]    err;
        logic signed [PROD_P_W-1:0] prod_p;
        logic signed [PROD_I_W-1:0] prod_i;
        logic signed [PROD_D_W-1:0] prod_d;
        logic                       in_deadband;
    } s2_t;

endpackage

`default_nettype wire

// ===== sv/wpid_ifs.sv =====
`default_nettype none

interface wpid_in_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [wpid_pkg::DATA_W-1:0]   target;
    logic signed [wpid_pkg::DATA_W-1:0]   measured;
    logic                                 restart;

    modport source (output valid, output target, output measured, output restart,
                    input ready);
    modport sink   (input valid, input target, input measured, input restart,
                    output ready);
endinterface

interface wpid_out_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [wpid_pkg::DRIVE_W-1:0]  drive;
    logic signed [wpid_pkg::ERR_W-1:0]    error;

    modport source (output valid, output drive, output error, input ready);
    modport sink   (input valid, input drive, input error, output ready);
endinterface

`default_nettype wire

// ===== sv/windowed_pid_step_top.sv =====
// Windowed PID step. Each input word carries a target, a measured value and a
// restart flag; each accepted word yields exactly one output word holding the
// error (target minus measured) and the saturated 16-bit drive. The block takes
// one word per clock cycle as long as the output side keeps taking words, and
// passes each word through the three pipeline registers; a stall on the output
// backs up through them without losing or repeating anything. The first
// stage closes the feedback loop combinationally: it forms the error, updates
// the windowed, saturating integral and the stored error, and works out the
// derivative, so consecutive words see each other's state with no bubble. The
// second stage holds the three gain multipliers, and the third sums the terms,
// scales by the gain fraction bits with truncation toward zero, saturates and
// applies the deadband. Setting restart clears the integral and stored error
// before that word is processed. Configuration registers sit on a simple APB
// port at byte addresses 0 to 24 and must only be written while no word is in
// flight; the block has no clearing pass and is ready straight after reset.
`default_nettype none

module windowed_pid_step_top #(
    parameter int GAIN_FRAC_BITS = 12
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [wpid_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [wpid_pkg::PDATA_W-1:0] pwdata,
    output logic      [wpid_pkg::PDATA_W-1:0] prdata,
    output logic                              pready,
    wpid_in_if.sink                           in_ch,
    wpid_out_if.source                        out_ch
);
    import wpid_pkg::*;

    cfg_t cfg;
    logic s1_valid;
    logic s1_ready;
    s1_t  s1;
    logic s2_valid;
    logic s2_ready;
    s2_t  s2;

    // Register file on the APB port.
    wpid_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Stage one: error, integral and derivative, with the controller state.
    wpid_state u_state (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .target   (in_ch.target),
        .measured (in_ch.measured),
        .restart  (in_ch.restart),
        .s1_valid (s1_valid),
        .s1_ready (s1_ready),
        .s1       (s1)
    );

    // Stage two: the three gain products.
    wpid_mult u_mult (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .s1_valid (s1_valid),
        .s1_ready (s1_ready),
        .s1       (s1),
        .s2_valid (s2_valid),
        .s2_ready (s2_ready),
        .s2       (s2)
    );

    // Stage three: sum, scaling, saturation, deadband and the output register.
    wpid_out #(
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .s2_valid  (s2_valid),
        .s2_ready  (s2_ready),
        .s2        (s2),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .drive     (out_ch.drive),
        .error     (out_ch.error)
    );

endmodule

`default_nettype wire

// ===== sv/wpid_cfg.sv =====
`default_nettype none

module wpid_cfg (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [wpid_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [wpid_pkg::PDATA_W-1:0] pwdata,
    output logic      [wpid_pkg::PDATA_W-1:0] prdata,
    output logic                              pready,
    output wpid_pkg::cfg_t                    cfg
);
    import wpid_pkg::*;

    cfg_t     cfg_reg;
    reg_idx_t idx;
    logic     wr_en;

    assign pready = 1'b1;
    assign idx    = paddr[ADDR_W-1:2];
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gain_p            <= RST_GAIN_P;
            cfg_reg.gain_i            <= RST_GAIN_I;
            cfg_reg.gain_d            <= RST_GAIN_D;
            cfg_reg.integral_window   <= RST_INT_WINDOW;
            cfg_reg.derivative_window <= RST_DER_WINDOW;
            cfg_reg.integral_limit    <= RST_INT_LIMIT;
            cfg_reg.output_deadband   <= RST_DEADBAND;
        end
        else if (wr_en)
        begin
            case (idx)
                REG_GAIN_P:     cfg_reg.gain_p            <= pwdata[GAIN_W-1:0];
                REG_GAIN_I:     cfg_reg.gain_i            <= pwdata[GAIN_W-1:0];
                REG_GAIN_D:     cfg_reg.gain_d            <= pwdata[GAIN_W-1:0];
                REG_INT_WINDOW: cfg_reg.integral_window   <= pwdata[WIN_W-1:0];
                REG_DER_WINDOW: cfg_reg.derivative_window <= pwdata[WIN_W-1:0];
                REG_INT_LIMIT:  cfg_reg.integral_limit    <= pwdata[LIMIT_W-1:0];
                REG_DEADBAND:   cfg_reg.output_deadband   <= pwdata[WIN_W-1:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_GAIN_P:     prdata = PDATA_W'(unsigned'(cfg_reg.gain_p));
            REG_GAIN_I:     prdata = PDATA_W'(unsigned'(cfg_reg.gain_i));
            REG_GAIN_D:     prdata = PDATA_W'(unsigned'(cfg_reg.gain_d));
            REG_INT_WINDOW: prdata = PDATA_W'(cfg_reg.integral_window);
            REG_DER_WINDOW: prdata = PDATA_W'(cfg_reg.derivative_window);
            REG_INT_LIMIT:  prdata = PDATA_W'(cfg_reg.integral_limit);
            REG_DEADBAND:   prdata = PDATA_W'(cfg_reg.output_deadband);
            default:        prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

// ===== sv/wpid_state.sv =====
`default_nettype none

`include "windowed_pid_step_top_defines.svh"

module wpid_state (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire wpid_pkg::cfg_t                     cfg,
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire logic signed [wpid_pkg::DATA_W-1:0] target,
    input  wire logic signed [wpid_pkg::DATA_W-1:0] measured,
    input  wire logic                               restart,
    output logic                                    s1_valid,
    input  wire logic                               s1_ready,
    output wpid_pkg::s1_t                           s1
);
    import wpid_pkg::*;

    logic                      accept;
    logic                      s1_valid_reg;
    s1_t                       s1_reg;
    s1_t                       s1_next;

    logic signed [ERR_W-1:0]   last_error_reg;
    logic signed [ERR_W-1:0]   last_error_next;
    logic signed [INTEG_W-1:0] acc_reg;
    logic signed [INTEG_W-1:0] acc_next;

    logic signed [ERR_W-1:0]   err;
    logic signed [ERR_W-1:0]   err_neg;
    logic [ERR_W-2:0]          aerr;
    logic signed [ERR_W-1:0]   last_eff;
    logic signed [INTEG_W-1:0] acc_eff;
    logic signed [INTEG_W-1:0] acc_neg;
    logic [INTEG_W-1:0]        acc_mag;
    logic signed [INTEG_W:0]   acc_sum;
    logic signed [INTEG_W:0]   lim_pos;
    logic signed [INTEG_W:0]   lim_neg;
    logic signed [INTEG_W-1:0] acc_clamped;
    logic signed [INTEG_W-1:0] acc_step;
    logic                      integ_go;
    logic                      integ_clear;
    logic signed [DERIV_W-1:0] deriv_raw;

    assign in_ready = !s1_valid_reg || s1_ready;
    assign accept   = in_valid && in_ready;
    assign s1_valid = s1_valid_reg;
    assign s1       = s1_reg;

    // A restart zeroes the stored state before this word is used.
    assign last_eff = restart ? '0 : last_error_reg;
    assign acc_eff  = restart ? '0 : acc_reg;

    assign err     = $signed({target[DATA_W-1], target})
                   - $signed({measured[DATA_W-1], measured});
    assign err_neg = -err;
    assign aerr    = err[ERR_W-1] ? err_neg[ERR_W-2:0] : err[ERR_W-2:0];

    assign acc_neg = -acc_eff;
    assign acc_mag = acc_eff[INTEG_W-1] ? acc_neg : acc_eff;

    assign integ_go = (aerr < cfg.integral_window)
                   && (acc_mag < {1'b0, cfg.integral_limit});

    assign acc_sum = $signed({acc_eff[INTEG_W-1], acc_eff})
                   + $signed({{(INTEG_W + 1 - ERR_W){err[ERR_W-1]}}, err});
    assign lim_pos = $signed({2'b00, cfg.integral_limit});
    assign lim_neg = -lim_pos;

    always_comb
    begin
        if (acc_sum > lim_pos)
            acc_clamped = lim_pos[INTEG_W-1:0];
        else if (acc_sum < lim_neg)
            acc_clamped = lim_neg[INTEG_W-1:0];
        else
            acc_clamped = acc_sum[INTEG_W-1:0];
    end

    assign acc_step = integ_go ? acc_clamped : acc_eff;

    // Clear on a zero error or on a sign change against the stored error.
    assign integ_clear = (err == '0)
                      || (!last_eff[ERR_W-1] && (last_eff != '0) && err[ERR_W-1])
                      || (last_eff[ERR_W-1] && !err[ERR_W-1] && (err != '0));

    assign acc_next        = integ_clear ? '0 : acc_step;
    assign last_error_next = err;

    assign deriv_raw = $signed({last_eff[ERR_W-1], last_eff}) - $signed({err[ERR_W-1], err});

    always_comb
    begin
        s1_next.err         = err;
        s1_next.integ       = acc_next;
        s1_next.deriv       = (aerr < cfg.derivative_window) ? deriv_raw : '0;
        s1_next.in_deadband = aerr < cfg.output_deadband;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            last_error_reg <= '0;
            acc_reg        <= '0;
        end
        else
        begin
            if (in_ready)
                s1_valid_reg <= in_valid;
            if (accept)
            begin
                last_error_reg <= last_error_next;
                acc_reg        <= acc_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            s1_reg <= s1_next;
    end

    `WPID_ASSERT_NEXT(a_zero_err_clears_integ, clk, rst_n,
        accept && (err == '0), acc_reg == '0,
        "integral not cleared on zero error")
    `WPID_ASSERT_NEXT(a_restart_no_integ, clk, rst_n,
        accept && restart && (aerr >= cfg.integral_window), acc_reg == '0,
        "restart did not clear the integral")
    `WPID_ASSERT_SAME(a_restart_deriv, clk, rst_n,
        accept && restart && (aerr < cfg.derivative_window),
        (s1_next.deriv + $signed({err[ERR_W-1], err})) == '0,
        "derivative after restart is not minus the error")

endmodule

`default_nettype wire

// ===== sv/wpid_mult.sv =====
`default_nettype none

module wpid_mult (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire wpid_pkg::cfg_t cfg,
    input  wire logic     s1_valid,
    output logic          s1_ready,
    input  wire wpid_pkg::s1_t s1,
    output logic          s2_valid,
    input  wire logic     s2_ready,
    output wpid_pkg::s2_t s2
);
    import wpid_pkg::*;

    logic s2_valid_reg;
    s2_t  s2_reg;
    s2_t  s2_next;
    logic advance;

    assign s1_ready = !s2_valid_reg || s2_ready;
    assign advance  = s1_valid && s1_ready;
    assign s2_valid = s2_valid_reg;
    assign s2       = s2_reg;

    // Three independent multipliers, one per term.
    always_comb
    begin
        s2_next.err         = s1.err;
        s2_next.prod_p      = PROD_P_W'($signed(s1.err))   * PROD_P_W'($signed(cfg.gain_p));
        s2_next.prod_i      = PROD_I_W'($signed(s1.integ)) * PROD_I_W'($signed(cfg.gain_i));
        s2_next.prod_d      = PROD_D_W'($signed(s1.deriv)) * PROD_D_W'($signed(cfg.gain_d));
        s2_next.in_deadband = s1.in_deadband;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (s1_ready)
            s2_valid_reg <= s1_valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            s2_reg <= s2_next;
    end

endmodule

`default_nettype wire

// ===== sv/wpid_out.sv =====
`default_nettype none

`include "windowed_pid_step_top_defines.svh"

module wpid_out #(
    parameter int GAIN_FRAC_BITS = 12
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                s2_valid,
    output logic                                     s2_ready,
    input  wire wpid_pkg::s2_t                       s2,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic signed [wpid_pkg::DRIVE_W-1:0]      drive,
    output logic signed [wpid_pkg::ERR_W-1:0]        error
);
    import wpid_pkg::*;

    localparam logic signed [SUM_W-1:0] ROUND_BIAS = SUM_W'((1 << GAIN_FRAC_BITS) - 1);
    localparam logic signed [SUM_W-1:0] SAT_HI     = SUM_W'(32767);
    localparam logic signed [SUM_W-1:0] SAT_LO     = SUM_W'(-32768);

    logic                      out_valid_reg;
    logic signed [DRIVE_W-1:0] drive_reg;
    logic signed [DRIVE_W-1:0] drive_next;
    logic signed [ERR_W-1:0]   error_reg;
    logic                      advance;
    logic signed [SUM_W-1:0]   sum;
    logic signed [SUM_W-1:0]   biased;
    logic signed [SUM_W-1:0]   scaled;

    assign s2_ready  = !out_valid_reg || out_ready;
    assign advance   = s2_valid && s2_ready;
    assign out_valid = out_valid_reg;
    assign drive     = drive_reg;
    assign error     = error_reg;

    assign sum = SUM_W'(s2.prod_p) + SUM_W'(s2.prod_i) + SUM_W'(s2.prod_d);

    // Bias negative sums so that the arithmetic shift truncates toward zero.
    assign biased = sum + (sum[SUM_W-1] ? ROUND_BIAS : '0);
    assign scaled = biased >>> GAIN_FRAC_BITS;

    always_comb
    begin
        if (s2.in_deadband)
            drive_next = '0;
        else if (scaled > SAT_HI)
            drive_next = SAT_HI[DRIVE_W-1:0];
        else if (scaled < SAT_LO)
            drive_next = SAT_LO[DRIVE_W-1:0];
        else
            drive_next = scaled[DRIVE_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s2_ready)
            out_valid_reg <= s2_valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            drive_reg <= drive_next;
            error_reg <= s2.err;
        end
    end

    `WPID_ASSERT_NEXT(a_deadband_zero_drive, clk, rst_n,
        advance && s2.in_deadband, out_valid_reg && (drive_reg == '0),
        "drive not zero inside the deadband")

endmodule

`default_nettype wire

// ===== tb/tb_windowed_pid_step_top.sv =====
`timescale 1ns / 100ps

module tb_windowed_pid_step_top;
    import wpid_pkg::*;

    // Clocking, run length and pressure settings.
    localparam int     HALF_PERIOD     = 2;
    localparam int     RESET_CYCLES    = 5;
    localparam int     GAIN_FRAC       = 12;
    localparam int     PIPE_DEPTH      = 3;
    localparam int     NUM_SETTINGS    = 8;
    localparam int     WORDS_PER_PHASE = 150;
    localparam int     HOLD_OFF_CYCLES = 120;
    localparam longint CYCLE_LIMIT     = 300000;
    localparam int     NUM_REGS        = 7;
    localparam int     NUM_DIRECTED    = 22;

    // Address one above the register list; writes there must be ignored.
    localparam reg_idx_t REG_UNUSED = 3'd7;

    localparam longint DRIVE_MAX = (longint'(1) <<< (DRIVE_W - 1)) - 1;
    localparam longint DRIVE_MIN = -(longint'(1) <<< (DRIVE_W - 1));

    localparam reg_idx_t ALL_REGS [NUM_REGS] = '{REG_GAIN_P, REG_GAIN_I, REG_GAIN_D,
        REG_INT_WINDOW, REG_DER_WINDOW, REG_INT_LIMIT, REG_DEADBAND};

    typedef enum int {RX_ALWAYS, RX_RANDOM, RX_PATTERN, RX_HEAVY} rx_mode_t;

    // One output word as the block should produce it.
    typedef struct packed {
        logic signed [DRIVE_W-1:0] drive;
        logic signed [ERR_W-1:0]   error;
    } pid_word_t;

    // A predicted word, plus the hand-worked value where the table row has one.
    typedef struct {
        pid_word_t predicted;
        bit        has_literal;
        int        literal_drive;
        int        literal_error;
    } pending_word_t;

    typedef struct {
        int target;
        int measured;
        bit restart;
        bit known;
        int drive;
        int error;
    } step_row_t;

    logic clk = 1'b0;
    logic rst_n;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [ADDR_W-1:0]    paddr;
    logic [PDATA_W-1:0]   pwdata;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;

    wpid_in_if  in_ch ();
    wpid_out_if out_ch ();

    windowed_pid_step_top #(
        .GAIN_FRAC_BITS (GAIN_FRAC)
    ) u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .in_ch   (in_ch),
        .out_ch  (out_ch)
    );

    always #(HALF_PERIOD) clk = ~clk;

    // Shadow copy of the controller: its register settings, the error kept from
    // the previous word and the windowed integral.
    cfg_t                      pid_cfg;
    logic signed [ERR_W-1:0]   stored_error;
    logic signed [INTEG_W-1:0] integral_acc;

    pending_word_t expected_results [$];

    int     fail_count       = 0;
    int     words_checked    = 0;
    int     drive_clamps     = 0;
    int     in_stall_cycles  = 0;
    int     settings_applied = 0;
    int     burst_left       = 0;
    int     run_sign         = 1;
    int     hold_off_requests = 0;
    int     hold_offs_served  = 0;
    longint cycle_count      = 0;

    // Hand-worked values of the table row now on the input, read by the monitor
    // when the word is taken.
    bit row_known;
    int row_drive;
    int row_error;

    string REG_NAMES [NUM_REGS] = '{"gain_p", "gain_i", "gain_d", "integral_window",
        "derivative_window", "integral_limit", "output_deadband"};

    int FIELD_EXTREMES [5] = '{-32768, -1, 0, 1, 32767};

    // The directed rows. Where the answer is plain from the reset settings
    // (gain_p 1.0, gain_i 0, deadband 50, windows 100 and 150) it is typed in;
    // the remaining rows walk the window and sign-change boundaries and are
    // checked against the predictor only.
    step_row_t directed_steps [NUM_DIRECTED] = '{
        '{0,      0,      1'b0, 1'b1, 0,      0},
        '{32767,  -32768, 1'b0, 1'b1, 32767,  65535},
        '{-32768, 32767,  1'b0, 1'b1, -32768, -65535},
        '{-32768, -32768, 1'b0, 1'b1, 0,      0},
        '{32767,  32767,  1'b1, 1'b1, 0,      0},
        '{10,     0,      1'b1, 1'b1, 0,      10},
        '{60,     0,      1'b0, 1'b0, 0,      0},
        '{60,     0,      1'b0, 1'b0, 0,      0},
        '{0,      70,     1'b0, 1'b0, 0,      0},
        '{99,     0,      1'b0, 1'b0, 0,      0},
        '{100,    0,      1'b0, 1'b0, 0,      0},
        '{149,    0,      1'b0, 1'b0, 0,      0},
        '{150,    0,      1'b0, 1'b0, 0,      0},
        '{0,      49,     1'b0, 1'b0, 0,      0},
        '{0,      50,     1'b0, 1'b0, 0,      0},
        '{-50,    0,      1'b0, 1'b0, 0,      0},
        '{120,    0,      1'b1, 1'b0, 0,      0},
        '{-1,     0,      1'b0, 1'b0, 0,      0},
        '{1,      0,      1'b0, 1'b0, 0,      0},
        '{12345,  -20000, 1'b0, 1'b1, 32345,  32345},
        '{-20000, 12345,  1'b0, 1'b1, -32345, -32345},
        '{0,      -32768, 1'b0, 1'b1, 32767,  32768}
    };

    // One controller step: restart, error, windowed and clamped integral, the
    // sign-change clear, the windowed derivative, then the scaled and saturated
    // drive with its deadband.
    function automatic pid_word_t predict_pid_step(logic signed [DATA_W-1:0] target,
                                                   logic signed [DATA_W-1:0] measured,
                                                   logic restart);
        pid_word_t res;
        longint    err;
        longint    err_mag;
        longint    acc;
        longint    acc_mag;
        longint    lim;
        longint    deriv;
        longint    sum;
        longint    drv;
        if (restart)
        begin
            stored_error = '0;
            integral_acc = '0;
        end
        err     = longint'(target) - longint'(measured);
        err_mag = (err < 0) ? -err : err;
        acc     = longint'(integral_acc);
        acc_mag = (acc < 0) ? -acc : acc;
        lim     = longint'($unsigned(pid_cfg.integral_limit));
        if (err_mag < longint'($unsigned(pid_cfg.integral_window)) && acc_mag < lim)
        begin
            acc = acc + err;
            if (acc > lim)
                acc = lim;
            if (acc < -lim)
                acc = -lim;
        end
        if (err == 0 || (stored_error > 0 && err < 0) || (stored_error < 0 && err > 0))
            acc = 0;
        if (err_mag < longint'($unsigned(pid_cfg.derivative_window)))
            deriv = longint'(stored_error) - err;
        else
            deriv = 0;
        stored_error = ERR_W'(err);
        integral_acc = INTEG_W'(acc);
        sum = err * longint'($signed(pid_cfg.gain_p))
            + acc * longint'($signed(pid_cfg.gain_i))
            + deriv * longint'($signed(pid_cfg.gain_d));
        // Division of signed integers truncates toward zero, as the block must.
        drv = sum / (longint'(1) <<< GAIN_FRAC);
        if (drv > DRIVE_MAX)
        begin
            drv = DRIVE_MAX;
            drive_clamps++;
        end
        if (drv < DRIVE_MIN)
        begin
            drv = DRIVE_MIN;
            drive_clamps++;
        end
        if (err_mag < longint'($unsigned(pid_cfg.output_deadband)))
            drv = 0;
        res.drive = DRIVE_W'(drv);
        res.error = ERR_W'(err);
        return res;
    endfunction

    function automatic logic [PDATA_W-1:0] reg_value(cfg_t c, reg_idx_t idx);
        case (idx)
            REG_GAIN_P:     return PDATA_W'($unsigned(c.gain_p));
            REG_GAIN_I:     return PDATA_W'($unsigned(c.gain_i));
            REG_GAIN_D:     return PDATA_W'($unsigned(c.gain_d));
            REG_INT_WINDOW: return PDATA_W'(c.integral_window);
            REG_DER_WINDOW: return PDATA_W'(c.derivative_window);
            REG_INT_LIMIT:  return PDATA_W'(c.integral_limit);
            REG_DEADBAND:   return PDATA_W'(c.output_deadband);
            default:        return '0;
        endcase
    endfunction

    function automatic logic [PDATA_W-1:0] reg_mask(reg_idx_t idx);
        if (idx == REG_INT_LIMIT)
            return {{(PDATA_W-LIMIT_W){1'b0}}, {LIMIT_W{1'b1}}};
        return {{(PDATA_W-WIN_W){1'b0}}, {WIN_W{1'b1}}};
    endfunction

    // Only the low bits of each register are kept; other addresses are ignored.
    function automatic void store_register(reg_idx_t idx, logic [PDATA_W-1:0] data);
        case (idx)
            REG_GAIN_P:     pid_cfg.gain_p            = data[GAIN_W-1:0];
            REG_GAIN_I:     pid_cfg.gain_i            = data[GAIN_W-1:0];
            REG_GAIN_D:     pid_cfg.gain_d            = data[GAIN_W-1:0];
            REG_INT_WINDOW: pid_cfg.integral_window   = data[WIN_W-1:0];
            REG_DER_WINDOW: pid_cfg.derivative_window = data[WIN_W-1:0];
            REG_INT_LIMIT:  pid_cfg.integral_limit    = data[LIMIT_W-1:0];
            REG_DEADBAND:   pid_cfg.output_deadband   = data[WIN_W-1:0];
            default: ;
        endcase
    endfunction

    function automatic int rand_s16();
        return int'($signed(DATA_W'($urandom)));
    endfunction

    // Register settings for each phase: a typical tuning, both extremes, a tight
    // integral limit that saturates, a full deadband, then random settings.
    function automatic cfg_t phase_setting(int phase);
        cfg_t c;
        case (phase)
            0: c = '{gain_p: 16'sd4096, gain_i: 16'sd409, gain_d: -16'sd3277,
                     integral_window: 16'd100, derivative_window: 16'd150,
                     integral_limit: 23'd10000, output_deadband: 16'd50};
            1: c = '{gain_p: 16'sh7FFF, gain_i: 16'sh7FFF, gain_d: 16'sh7FFF,
                     integral_window: 16'hFFFF, derivative_window: 16'hFFFF,
                     integral_limit: 23'h7FFFFF, output_deadband: 16'd0};
            2: c = '{gain_p: 16'sh8000, gain_i: 16'sh8000, gain_d: 16'sh8000,
                     integral_window: 16'd0, derivative_window: 16'd0,
                     integral_limit: 23'd0, output_deadband: 16'd0};
            3: c = '{gain_p: 16'sd1024, gain_i: 16'sd30000, gain_d: 16'sd0,
                     integral_window: 16'd2000, derivative_window: 16'd0,
                     integral_limit: 23'd300, output_deadband: 16'd1};
            4: c = '{gain_p: 16'sd2048, gain_i: 16'sd100, gain_d: -16'sd1000,
                     integral_window: 16'hFFFF, derivative_window: 16'd400,
                     integral_limit: 23'h7FFFFF, output_deadband: 16'hFFFF};
            default:
            begin
                c.gain_p            = GAIN_W'($urandom);
                c.gain_i            = GAIN_W'($urandom);
                c.gain_d            = GAIN_W'($urandom);
                c.integral_window   = WIN_W'($urandom_range(0, 600));
                c.derivative_window = WIN_W'($urandom_range(0, 600));
                if ($urandom_range(0, 3) == 0)
                    c.integral_limit = LIMIT_W'($urandom);
                else
                    c.integral_limit = LIMIT_W'($urandom_range(0, 5000));
                c.output_deadband   = WIN_W'($urandom_range(0, 80));
            end
        endcase
        return c;
    endfunction

    // APB write: setup cycle, then the access cycle, completing on pready.
    task automatic apb_write(reg_idx_t idx, logic [PDATA_W-1:0] data);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = data;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic apb_read(reg_idx_t idx, output logic [PDATA_W-1:0] data);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = {idx, 2'b00};
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        data = prdata;
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    task automatic check_registers();
        logic [PDATA_W-1:0] rd;
        for (int i = 0; i < NUM_REGS; i++)
        begin
            apb_read(ALL_REGS[i], rd);
            if ((rd & reg_mask(ALL_REGS[i])) !== reg_value(pid_cfg, ALL_REGS[i]))
            begin
                $error("%s mismatch on read-back: expected %0h, got %0h", REG_NAMES[i],
                       reg_value(pid_cfg, ALL_REGS[i]), rd & reg_mask(ALL_REGS[i]));
                fail_count++;
            end
        end
    endtask

    // Writes every register with random junk above its width, pokes the unused
    // address, then reads the lot back.
    task automatic apply_setting(cfg_t c);
        logic [PDATA_W-1:0] data;
        for (int i = 0; i < NUM_REGS; i++)
        begin
            data = reg_value(c, ALL_REGS[i]) | (PDATA_W'($urandom) & ~reg_mask(ALL_REGS[i]));
            apb_write(ALL_REGS[i], data);
            store_register(ALL_REGS[i], data);
        end
        data = PDATA_W'($urandom);
        apb_write(REG_UNUSED, data);
        store_register(REG_UNUSED, data);
        check_registers();
        settings_applied++;
    endtask

    // Offers one word, opening a new burst after a random gap when the current
    // one is used up, and returns at the falling edge after it was taken.
    task automatic send_word(int t, int m, bit r);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0)
            begin
                in_ch.valid = 1'b0;
                repeat (gap) @(negedge clk);
            end
            if ($urandom_range(0, 7) == 0)
                burst_left = $urandom_range(40, 90);
            else
                burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        in_ch.target   = DATA_W'(t);
        in_ch.measured = DATA_W'(m);
        in_ch.restart  = r;
        in_ch.valid    = 1'b1;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic wait_for_drain();
        in_ch.valid = 1'b0;
        while (expected_results.size() != 0)
            @(negedge clk);
        repeat (PIPE_DEPTH + 1) @(negedge clk);
    endtask

    task automatic compare_field(string name, logic signed [31:0] want,
                                 logic signed [31:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    // Scoreboard. Every word taken on the input is predicted straight away, with
    // the settings it will see, and queued; every word taken on the output is
    // checked against the oldest prediction in the queue.
    always @(posedge clk)
    begin
        pending_word_t pend;
        if (rst_n)
        begin
            if (in_ch.valid && !in_ch.ready)
                in_stall_cycles++;
            if (in_ch.valid && in_ch.ready)
            begin
                pend.predicted     = predict_pid_step(in_ch.target, in_ch.measured,
                                                      in_ch.restart);
                pend.has_literal   = row_known;
                pend.literal_drive = row_drive;
                pend.literal_error = row_error;
                expected_results.push_back(pend);
            end
            if (out_ch.valid && out_ch.ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("output word with none expected: drive %0d, error %0d",
                           out_ch.drive, out_ch.error);
                    fail_count++;
                end
                else
                begin
                    pend = expected_results.pop_front();
                    compare_field("drive", pend.predicted.drive, out_ch.drive);
                    compare_field("error", pend.predicted.error, out_ch.error);
                    if (pend.has_literal)
                    begin
                        compare_field("drive (table)", pend.literal_drive, out_ch.drive);
                        compare_field("error (table)", pend.literal_error, out_ch.error);
                    end
                    words_checked++;
                end
            end
        end
    end

    // Output side. It changes its ready pattern every so often: always ready,
    // random, a fixed one-in-five stall and heavy random stalling. When asked,
    // it holds ready low for a long stretch so that the pipeline fills and the
    // input is pushed back.
    initial
    begin
        rx_mode_t mode;
        int       left;
        int       beat;
        mode = RX_ALWAYS;
        left = 0;
        beat = 0;
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off_requests != hold_offs_served)
            begin
                hold_offs_served++;
                out_ch.ready = 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge clk);
            end
            if (left == 0)
            begin
                mode = rx_mode_t'($urandom_range(0, 3));
                left = $urandom_range(20, 150);
            end
            left--;
            beat++;
            case (mode)
                RX_ALWAYS:  out_ch.ready = 1'b1;
                RX_RANDOM:  out_ch.ready = ($urandom_range(0, 3) != 0);
                RX_PATTERN: out_ch.ready = ((beat % 5) != 0);
                default:    out_ch.ready = ($urandom_range(0, 9) < 3);
            endcase
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Run stopped after %0d cycles with %0d words still expected",
                     cycle_count, expected_results.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        int t;
        int m;
        int e;
        int span;
        int pick;
        bit r;

        rst_n          = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        in_ch.valid    = 1'b0;
        in_ch.target   = '0;
        in_ch.measured = '0;
        in_ch.restart  = 1'b0;
        row_known      = 1'b0;
        row_drive      = 0;
        row_error      = 0;

        pid_cfg = '{gain_p: RST_GAIN_P, gain_i: RST_GAIN_I, gain_d: RST_GAIN_D,
                    integral_window: RST_INT_WINDOW, derivative_window: RST_DER_WINDOW,
                    integral_limit: RST_INT_LIMIT, output_deadband: RST_DEADBAND};
        stored_error = '0;
        integral_acc = '0;

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // The reset settings must read back before anything is written.
        check_registers();

        // Directed rows under the reset settings.
        for (int i = 0; i < NUM_DIRECTED; i++)
        begin
            row_known = directed_steps[i].known;
            row_drive = directed_steps[i].drive;
            row_error = directed_steps[i].error;
            send_word(directed_steps[i].target, directed_steps[i].measured,
                      directed_steps[i].restart);
        end
        row_known = 1'b0;
        wait_for_drain();

        // Random phases. Most words track a setpoint with small errors that keep
        // one sign for a while, so the integral builds, clamps and is cleared by
        // a sign change; the rest are full-range noise and field extremes.
        for (int phase = 0; phase < NUM_SETTINGS; phase++)
        begin
            apply_setting(phase_setting(phase));
            if (phase == 1 || phase == 5)
                hold_off_requests++;
            span = int'(pid_cfg.integral_window);
            if (int'(pid_cfg.derivative_window) > span)
                span = int'(pid_cfg.derivative_window);
            if (int'(pid_cfg.output_deadband) > span)
                span = int'(pid_cfg.output_deadband);
            if (span > 3000)
                span = 3000;
            span = span + 40;
            for (int n = 0; n < WORDS_PER_PHASE; n++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 4)
                begin
                    t = FIELD_EXTREMES[$urandom_range(0, 4)];
                    m = FIELD_EXTREMES[$urandom_range(0, 4)];
                end
                else if (pick < 16)
                begin
                    t = rand_s16();
                    m = rand_s16();
                end
                else
                begin
                    if ($urandom_range(0, 99) < 12)
                        run_sign = -run_sign;
                    e = run_sign * $urandom_range(0, span);
                    t = rand_s16();
                    m = t - e;
                    if (m > 32767)
                        m = 32767;
                    if (m < -32768)
                        m = -32768;
                end
                r = ($urandom_range(0, 99) < 4);
                send_word(t, m, r);
            end
            wait_for_drain();
        end

        // Let anything stray come out before the verdict.
        repeat (PIPE_DEPTH * 4) @(negedge clk);
        if (expected_results.size() != 0)
        begin
            $error("%0d expected words never arrived", expected_results.size());
            fail_count++;
        end

        $display("Checked %0d words across %0d register settings plus the reset ones.",
                 words_checked, settings_applied);
        $display("Input was held back for %0d cycles; the drive saturated %0d times.",
                 in_stall_cycles, drive_clamps);
        if (fail_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
